// File: rtl/core/aec_pkg.sv
// Shared types and codes of the argumentation extension check unit.
// Used by aec_edge_store and argumentation_extension_check_unit; no dependencies.
package aec_pkg;

	localparam logic [1:0] OP_EDGE  = 2'd0;
	localparam logic [1:0] OP_ARG   = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;

	localparam logic [1:0] SEM_CONFLICT_FREE = 2'd0;
	localparam logic [1:0] SEM_ADMISSIBLE    = 2'd1;
	localparam logic [1:0] SEM_COMPLETE      = 2'd2;
	localparam logic [1:0] SEM_STABLE        = 2'd3;

	localparam logic REG_NUM_ARGS  = 1'b0;
	localparam logic REG_SEMANTICS = 1'b1;

	localparam int CFG_DATA_W = 7;
	localparam logic [6:0] NUM_ARGS_RESET = 7'd64;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} aec_mem_ctl_t;

endpackage

// File: rtl/core/aec_edge_store.sv
// Attack relation stores: rows by attacker and columns by target.
// Two synchronous memories with a registered read. Depends on aec_pkg.
module aec_edge_store #(
	parameter int MAX_ARGS = 64,
	localparam int AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1
) (
	input  logic                 clk,
	input  aec_pkg::aec_mem_ctl_t ctl,
	input  logic [AW-1:0]        row_addr,
	input  logic [AW-1:0]        col_addr,
	input  logic [MAX_ARGS-1:0]  row_wdata,
	input  logic [MAX_ARGS-1:0]  col_wdata,
	output logic [MAX_ARGS-1:0]  row_rdata,
	output logic [MAX_ARGS-1:0]  col_rdata
);

	logic [MAX_ARGS-1:0] rows_mem [MAX_ARGS];
	logic [MAX_ARGS-1:0] cols_mem [MAX_ARGS];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			rows_mem[row_addr] <= row_wdata;
			cols_mem[col_addr] <= col_wdata;
		end
		if (ctl.rd_en) begin
			row_rdata <= rows_mem[row_addr];
			col_rdata <= cols_mem[col_addr];
		end
	end

endmodule

// File: rtl/core/argumentation_extension_check_unit.sv
// Top level of the argumentation extension check unit: control, sets, scans.
// Depends on aec_pkg and aec_edge_store.
//
// channel   direction  signals                                          handshake
// item      in         op attacker_index target_index edge_present      start & !busy
//                      arg_index active_flag member_flag
// result    out        verdict                                          done, 1 cycle
// config    in         cfg_index cfg_data                               cfg_write
//
// Argument load writes the flags in idle. Edge load reads both stores, then
// writes them back. Check: a first scan over both stores, a second one for
// admissible and complete, each over n = min(num_args, MAX_ARGS) arguments;
// the verdict shows with done. Reset starts a clearing pass over all MAX_ARGS
// rows of both stores with busy high. The receiver cannot stall; done lasts
// one cycle and the next item may be taken in that same cycle.
module argumentation_extension_check_unit #(
	parameter int MAX_ARGS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] op,
	input  logic [5:0] attacker_index,
	input  logic [5:0] target_index,
	input  logic       edge_present,
	input  logic [5:0] arg_index,
	input  logic       active_flag,
	input  logic       member_flag,
	output logic       done,
	output logic       verdict,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [aec_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
	localparam int CW = $clog2(MAX_ARGS + 1);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_E_RD = 3'd2;
	localparam logic [2:0] ST_E_WR = 3'd3;
	localparam logic [2:0] ST_P1   = 3'd4;
	localparam logic [2:0] ST_P2   = 3'd5;

	logic [2:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       n_eff_q;
	logic [6:0]          num_args_q;
	logic [1:0]          semantics_q;
	logic [MAX_ARGS-1:0] active_q;
	logic [MAX_ARGS-1:0] member_q;
	logic [MAX_ARGS-1:0] hit_q;
	logic [AW-1:0]       e_a_q;
	logic [AW-1:0]       e_t_q;
	logic                e_on_q;
	logic                v_s1;
	logic [AW-1:0]       idx_s1;
	logic                cf_fail_q;
	logic                adm_fail_q;
	logic                cmp_fail_q;
	logic                st_fail_q;
	logic                done_q;
	logic                verdict_q;

	aec_pkg::aec_mem_ctl_t mem_ctl;
	logic [AW-1:0]       row_addr;
	logic [AW-1:0]       col_addr;
	logic [MAX_ARGS-1:0] row_wdata;
	logic [MAX_ARGS-1:0] col_wdata;
	logic [MAX_ARGS-1:0] row_rdata;
	logic [MAX_ARGS-1:0] col_rdata;

	logic [MAX_ARGS-1:0] lim_mask;
	logic [MAX_ARGS-1:0] act_m;
	logic [MAX_ARGS-1:0] mem_m;
	logic                accept;
	logic                edge_ok;
	logic                arg_ok;
	logic                scan_issue;
	logic                scan_end;
	logic                hit_now;
	logic                conflict_now;
	logic                defended_now;
	logic                final_verdict;
	logic [CW-1:0]       n_eff_d;

	aec_edge_store #(
		.MAX_ARGS(MAX_ARGS)
	) u_store (
		.clk      (clk),
		.ctl      (mem_ctl),
		.row_addr (row_addr),
		.col_addr (col_addr),
		.row_wdata(row_wdata),
		.col_wdata(col_wdata),
		.row_rdata(row_rdata),
		.col_rdata(col_rdata)
	);

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign edge_ok = (int'(attacker_index) < MAX_ARGS) && (int'(target_index) < MAX_ARGS);
	assign arg_ok  = (int'(arg_index) < MAX_ARGS);
	assign n_eff_d = (int'(num_args_q) > MAX_ARGS) ? CW'(MAX_ARGS) : CW'(num_args_q);

	always_comb begin
		for (int i = 0; i < MAX_ARGS; i++) begin
			lim_mask[i] = (i < int'(n_eff_q));
		end
	end

	assign act_m = active_q & lim_mask;
	assign mem_m = member_q & lim_mask;

	assign scan_issue = ((state_q == ST_P1) || (state_q == ST_P2)) && (cnt_q < n_eff_q);
	assign scan_end   = (cnt_q == n_eff_q) && !v_s1;

	assign hit_now      = |(col_rdata & act_m & mem_m);
	assign conflict_now = |(row_rdata & act_m & mem_m);
	assign defended_now = ~|(col_rdata & act_m & ~hit_q);

	always_comb begin
		case (semantics_q)
			aec_pkg::SEM_CONFLICT_FREE: final_verdict = !cf_fail_q;
			aec_pkg::SEM_ADMISSIBLE:    final_verdict = !cf_fail_q && !adm_fail_q;
			aec_pkg::SEM_COMPLETE:      final_verdict = !cf_fail_q && !adm_fail_q && !cmp_fail_q;
			default:                    final_verdict = !cf_fail_q && !st_fail_q;
		endcase
	end

	always_comb begin
		mem_ctl.rd_en = 1'b0;
		mem_ctl.wr_en = 1'b0;
		row_addr      = cnt_q[AW-1:0];
		col_addr      = cnt_q[AW-1:0];
		row_wdata     = '0;
		col_wdata     = '0;
		case (state_q)
			ST_CLR: begin
				mem_ctl.wr_en = 1'b1;
			end
			ST_E_RD: begin
				mem_ctl.rd_en = 1'b1;
				row_addr      = e_a_q;
				col_addr      = e_t_q;
			end
			ST_E_WR: begin
				mem_ctl.wr_en    = 1'b1;
				row_addr         = e_a_q;
				col_addr         = e_t_q;
				row_wdata        = row_rdata;
				col_wdata        = col_rdata;
				row_wdata[e_t_q] = e_on_q;
				col_wdata[e_a_q] = e_on_q;
			end
			ST_P1, ST_P2: begin
				mem_ctl.rd_en = scan_issue;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_args_q  <= aec_pkg::NUM_ARGS_RESET;
			semantics_q <= aec_pkg::SEM_CONFLICT_FREE;
		end else if (cfg_write) begin
			case (cfg_index)
				aec_pkg::REG_NUM_ARGS:  num_args_q  <= cfg_data;
				aec_pkg::REG_SEMANTICS: semantics_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			cnt_q      <= '0;
			n_eff_q    <= '0;
			active_q   <= '0;
			member_q   <= '0;
			v_s1       <= 1'b0;
			cf_fail_q  <= 1'b0;
			adm_fail_q <= 1'b0;
			cmp_fail_q <= 1'b0;
			st_fail_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= scan_issue;
			if (scan_issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(MAX_ARGS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (op)
							aec_pkg::OP_EDGE: begin
								if (edge_ok) begin
									state_q <= ST_E_RD;
								end
							end
							aec_pkg::OP_ARG: begin
								if (arg_ok) begin
									active_q[AW'(arg_index)] <= active_flag;
									member_q[AW'(arg_index)] <= member_flag;
								end
							end
							aec_pkg::OP_CHECK: begin
								n_eff_q    <= n_eff_d;
								cnt_q      <= '0;
								cf_fail_q  <= 1'b0;
								adm_fail_q <= 1'b0;
								cmp_fail_q <= 1'b0;
								st_fail_q  <= 1'b0;
								state_q    <= ST_P1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_E_RD: begin
					state_q <= ST_E_WR;
				end
				ST_E_WR: begin
					state_q <= ST_IDLE;
				end
				ST_P1: begin
					if (v_s1) begin
						if (mem_m[idx_s1] && conflict_now) begin
							cf_fail_q <= 1'b1;
						end
						if (act_m[idx_s1] && !mem_m[idx_s1] && !hit_now) begin
							st_fail_q <= 1'b1;
						end
					end
					if (scan_end) begin
						cnt_q <= '0;
						if ((semantics_q == aec_pkg::SEM_ADMISSIBLE) ||
							(semantics_q == aec_pkg::SEM_COMPLETE)) begin
							state_q <= ST_P2;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				ST_P2: begin
					if (v_s1) begin
						if (mem_m[idx_s1] && !defended_now) begin
							adm_fail_q <= 1'b1;
						end
						if (act_m[idx_s1] && !mem_m[idx_s1] && defended_now) begin
							cmp_fail_q <= 1'b1;
						end
					end
					if (scan_end) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// attacked-by-active-member bit per argument, built in the first scan
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		if (accept && (op == aec_pkg::OP_EDGE)) begin
			e_a_q  <= AW'(attacker_index);
			e_t_q  <= AW'(target_index);
			e_on_q <= edge_present;
		end
		if ((state_q == ST_P1) && v_s1) begin
			hit_q[idx_s1] <= hit_now;
		end
		if (scan_end && ((state_q == ST_P1) || (state_q == ST_P2))) begin
			verdict_q <= final_verdict;
		end
	end

	assign done    = done_q;
	assign verdict = verdict_q;

	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_P1) || ($past(state_q) == ST_P2))
		else $error("done without a finished scan");

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_P1) || (state_q == ST_P2))
		else $error("read data pending outside a scan");

	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr_en |-> (state_q == ST_CLR) || (state_q == ST_E_WR))
		else $error("store written outside clear or edge update");

	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_E_WR) |-> ($past(state_q) == ST_E_RD))
		else $error("edge write-back without a read");

endmodule
